// ===== hdl/next_fit_slot_allocator_unit_macros.svh =====
// Assertion macros shared by the checker file of the slot allocator.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFSA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NFSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== hdl/nfsa_pkg.sv =====
`default_nettype none

package nfsa_pkg;

	// Store geometry. The occupancy map is held as words of WORD_W bits.
	localparam int SLOTS     = 256;
	localparam int ID_W      = 9;
	localparam int WORD_W    = (SLOTS >= 32) ? 32 : (2 ** $clog2(SLOTS));
	localparam int WORDS     = (SLOTS + WORD_W - 1) / WORD_W;
	localparam int BIT_W     = (WORD_W > 1) ? $clog2(WORD_W) : 1;
	localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int K_W       = $clog2(WORDS + 1);
	localparam int LAST_BITS = SLOTS - (WORDS - 1) * WORD_W;

	// Bits of the last word that belong to real slots.
	localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NONE     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t            command;
		logic [ID_W-1:0] slot_id;
	} req_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] given_id;
		logic            occupied;
	} rsp_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} ff_t;

	// Lowest set bit of a word.
	function automatic ff_t find_first(input logic [WORD_W-1:0] v);
		ff_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.found = 1'b1;
				r.idx   = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/nfsa_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered read data.
module nfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/next_fit_slot_allocator_unit.sv =====
// Next-fit slot allocator. A request is a command (allocate, free, lookup, clear all) with a
// slot id, and every request gives exactly one response. One request is worked on at a time:
// free, lookup and clear read the occupancy word at transfer and then check it (free also
// writes it back), and allocate also reads one further occupancy word for each step that
// the search goes on. The store holds 256 slots in eight 32-bit words. The search is bounded
// by the single read port of the occupancy RAM, which delivers one word per cycle to the
// find-first logic. The response is registered once the output register is free. A per-word
// valid flag, cleared at reset and by clear all, makes an empty store read as zero, so there
// is no clearing pass after reset. A new request is taken while the previous response still
// waits in the output register.
`default_nettype none

module next_fit_slot_allocator_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire nfsa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output nfsa_pkg::rsp_t     rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_BUSY = 2'b10
	} state_t;

	state_t                            state_q;
	nfsa_pkg::cmd_t                    cmd_q;
	logic [nfsa_pkg::ID_W-1:0]         id_q;
	logic                              id_zero_q;
	logic                              id_oob_q;
	logic [nfsa_pkg::BIT_W-1:0]        id_bit_q;
	logic [nfsa_pkg::WADDR_W-1:0]      cur_word_q;
	logic [nfsa_pkg::K_W-1:0]          k_q;
	logic [nfsa_pkg::WADDR_W-1:0]      ptr_word_q;
	logic [nfsa_pkg::BIT_W-1:0]        ptr_bit_q;
	logic [nfsa_pkg::WORDS-1:0]        row_valid_q;
	logic                              rd_valid_s1;
	logic                              rsp_valid_q;
	nfsa_pkg::rsp_t                    rsp_q;

	logic                              acc;
	logic [nfsa_pkg::ID_W-1:0]         idm1;
	logic                              id_zero;
	logic                              id_oob;
	logic [nfsa_pkg::WADDR_W-1:0]      id_word;
	logic [nfsa_pkg::BIT_W-1:0]        id_bit;
	logic                              rd_en;
	logic [nfsa_pkg::WADDR_W-1:0]      rd_addr;
	logic [nfsa_pkg::WORD_W-1:0]       rd_data;
	logic [nfsa_pkg::WORD_W-1:0]       word;
	logic [nfsa_pkg::WORD_W-1:0]       range_mask;
	logic [nfsa_pkg::WORD_W-1:0]       low_mask;
	logic [nfsa_pkg::WORD_W-1:0]       pos_mask;
	logic [nfsa_pkg::WORD_W-1:0]       id_onehot;
	nfsa_pkg::ff_t                     ff;
	logic                              last;
	logic [nfsa_pkg::WADDR_W-1:0]      next_word;
	logic                              busy;
	logic                              out_free;
	logic                              alloc_cont;
	logic                              finish;
	logic                              wr_need;
	logic                              wr_en;
	logic [nfsa_pkg::WORD_W-1:0]       wr_data;
	logic                              do_clear;
	logic                              do_move;
	nfsa_pkg::rsp_t                    rsp_n;

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign busy      = (state_q == S_BUSY);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Decode the requested id into word and bit of the occupancy map.
	assign idm1    = req.slot_id - 1'b1;
	assign id_zero = (req.slot_id == '0);
	assign id_oob  = (32'(req.slot_id) > 32'(nfsa_pkg::SLOTS));
	assign id_bit  = nfsa_pkg::BIT_W'(idm1 % nfsa_pkg::WORD_W);
	assign id_word = (id_zero || id_oob) ? '0
		: nfsa_pkg::WADDR_W'(idm1 / nfsa_pkg::WORD_W);

	// Search window within the word under test.
	assign word       = rd_data & {nfsa_pkg::WORD_W{rd_valid_s1}};
	assign range_mask = (cur_word_q == nfsa_pkg::WADDR_W'(nfsa_pkg::WORDS - 1))
		? nfsa_pkg::LAST_MASK : '1;
	assign low_mask   = (nfsa_pkg::WORD_W'(1) << ptr_bit_q) - 1'b1;
	assign last       = (k_q == nfsa_pkg::K_W'(nfsa_pkg::WORDS));
	assign pos_mask   = (k_q == '0) ? ~low_mask : (last ? low_mask : '1);
	assign ff         = nfsa_pkg::find_first(~word & range_mask & pos_mask);
	assign next_word  = (cur_word_q == nfsa_pkg::WADDR_W'(nfsa_pkg::WORDS - 1))
		? '0 : cur_word_q + 1'b1;
	assign id_onehot  = nfsa_pkg::WORD_W'(1) << id_bit_q;

	// Step control: keep searching, or finish once the output register is free.
	assign alloc_cont = busy && (cmd_q == nfsa_pkg::CMD_ALLOC) && !ff.found && !last;
	assign finish     = busy && !alloc_cont && out_free;

	// Occupancy RAM read: first word at transfer, following words while searching.
	assign rd_en   = acc || alloc_cont;
	assign rd_addr = acc
		? ((req.command == nfsa_pkg::CMD_ALLOC) ? ptr_word_q : id_word)
		: next_word;

	// Result and write-back of the request in hand.
	always_comb begin
		rsp_n    = '{status: nfsa_pkg::ST_OK, given_id: '0, occupied: 1'b0};
		wr_need  = 1'b0;
		wr_data  = word;
		do_clear = 1'b0;
		do_move  = 1'b0;
		case (cmd_q)
			nfsa_pkg::CMD_ALLOC: begin
				if (ff.found) begin
					rsp_n.given_id = nfsa_pkg::ID_W'(
						{1'b0, cur_word_q, ff.idx} + 1'b1);
					rsp_n.occupied = 1'b1;
					wr_need        = 1'b1;
					wr_data        = word | (nfsa_pkg::WORD_W'(1) << ff.idx);
					do_move        = 1'b1;
				end else begin
					rsp_n.status = nfsa_pkg::ST_FULL;
				end
			end
			nfsa_pkg::CMD_FREE, nfsa_pkg::CMD_LOOKUP: begin
				if (id_zero_q) begin
					rsp_n.status = nfsa_pkg::ST_NONE;
				end else if (id_oob_q || !word[id_bit_q]) begin
					rsp_n.status = nfsa_pkg::ST_NOTFOUND;
				end else begin
					rsp_n.given_id = id_q;
					rsp_n.occupied = (cmd_q == nfsa_pkg::CMD_LOOKUP);
					wr_need        = (cmd_q == nfsa_pkg::CMD_FREE);
					wr_data        = word & ~id_onehot;
				end
			end
			nfsa_pkg::CMD_CLEAR: begin
				do_clear = 1'b1;
			end
			default: begin
				rsp_n.status = nfsa_pkg::ST_NONE;
			end
		endcase
	end

	assign wr_en = finish && wr_need;

	nfsa_ram #(
		.WIDTH (nfsa_pkg::WORD_W),
		.DEPTH (nfsa_pkg::WORDS),
		.AW    (nfsa_pkg::WADDR_W)
	) u_occ_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cur_word_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_BUSY;
					end
				end
				S_BUSY: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields held for the evaluation cycles.
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q     <= req.command;
			id_q      <= req.slot_id;
			id_zero_q <= id_zero;
			id_oob_q  <= id_oob;
			id_bit_q  <= id_bit;
		end
	end

	// Word under test and search step count.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_word_q <= rd_addr;
			k_q        <= acc ? '0 : k_q + 1'b1;
		end
	end

	// Valid flag of the word being read, sampled alongside the RAM.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_valid_s1 <= row_valid_q[rd_addr];
		end
	end

	// Per-word valid flags and the next-fit pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			ptr_word_q  <= '0;
			ptr_bit_q   <= '0;
		end else if (finish) begin
			if (do_clear) begin
				row_valid_q <= '0;
				ptr_word_q  <= '0;
				ptr_bit_q   <= '0;
			end else begin
				if (wr_need) begin
					row_valid_q[cur_word_q] <= 1'b1;
				end
				if (do_move) begin
					ptr_word_q <= cur_word_q;
					ptr_bit_q  <= ff.idx;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nfsa_checker.sv =====
`default_nettype none

`include "next_fit_slot_allocator_unit_macros.svh"

// Port-level checks on the slot allocator.
module nfsa_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire nfsa_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire nfsa_pkg::rsp_t rsp
);

	// A stalled response holds its value.
	`NFSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// Only one request is in work at a time.
	`NFSA_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready)

	// A failed request carries no id and no occupancy.
	`NFSA_ASSERT_SAME(a_fail_clean, rsp_valid && rsp.status != nfsa_pkg::ST_OK,
		rsp.given_id == '0 && !rsp.occupied)

	// An occupied slot is always named by a real id.
	`NFSA_ASSERT_SAME(a_occ_id, rsp_valid && rsp.occupied,
		rsp.given_id != '0 && 32'(rsp.given_id) <= 32'(nfsa_pkg::SLOTS))

endmodule

bind next_fit_slot_allocator_unit nfsa_checker u_nfsa_checker (.*);

`default_nettype wire
